// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/e2e_pkg.sv -----
// Package for the CRC-32 frame checker: types, codes, CRC byte update.
// No dependencies.
package e2e_pkg;
  localparam int unsigned MaxFrameBytes = 256;
  localparam logic [31:0] CrcPolyRefl = 32'hEDB88320;
  localparam logic [11:0] ByteCntMax = 12'd4095;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_SOME_LOST = 3'd1, ST_REPEATED = 3'd2, ST_SYNC = 3'd3,
    ST_INITIAL = 3'd4, ST_WRONG_CRC = 3'd5, ST_INPUT_ERR = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    REG_MIN_LEN = 3'd0, REG_MAX_LEN = 3'd1, REG_CRC_OFS = 3'd2, REG_CNT_OFS = 3'd3,
    REG_DATA_ID = 3'd4, REG_INC_ID = 3'd5, REG_MAX_DELTA = 3'd6
  } reg_e;

  // Per-frame summary handed from front to back.
  typedef struct packed {
    logic [12:0] length;   // up to 4096 once the byte count saturates
    logic [31:0] crc;      // running CRC, not yet inverted, without data ID
    logic [31:0] rx_crc;
    logic        crc_ok;   // all four CRC bytes seen
    logic [7:0]  cnt;
    logic        cnt_ok;
  } frame_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ CrcPolyRefl) : (r >> 1);
    return r;
  endfunction
endpackage

// ----- hw/rtl/e2e_front.sv -----
// Front part: per-byte CRC update and CRC/counter field capture.
// Depends on e2e_pkg.
module e2e_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_fire_i,
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  input  logic [10:0]          crc_ofs_i,
  input  logic [10:0]          cnt_ofs_i,
  output logic                 frame_valid_o,
  output e2e_pkg::frame_t      frame_o
);
  logic [31:0] crc_q, crc_d;
  logic [11:0] cnt_q, cnt_d;
  logic [31:0] rxc_q, rxc_d;
  logic [2:0]  crcs_q, crcs_d;
  logic [7:0]  cb_q, cb_d, cb_new;
  logic [3:0]  cbs_q, cbs_d;
  logic [7:0]  crc_pos, cnt_pos;
  logic [2:0]  sh;
  logic        in_crc;
  logic [4:0]  cbs_sum;

  assign crc_pos = crc_ofs_i[10:3];
  assign cnt_pos = cnt_ofs_i[10:3];
  assign sh = cnt_ofs_i[2:0];
  // current byte lies in the four-byte CRC field
  assign in_crc = (cnt_q >= {4'd0, crc_pos}) && (cnt_q < {4'd0, crc_pos} + 12'd4);

  always_comb begin
    crc_d = crc_q; cnt_d = cnt_q; rxc_d = rxc_q; crcs_d = crcs_q;
    cb_new = cb_q; cbs_d = cbs_q; cbs_sum = {1'b0, cbs_q};
    if (in_fire_i) begin
      if (in_crc && crcs_q < 3'd4) begin
        rxc_d = {rxc_q[23:0], byte_i};
        crcs_d = crcs_q + 3'd1;
      end
      crc_d = e2e_pkg::crc_byte(crc_q, in_crc ? 8'd0 : byte_i);
      if (cnt_q == {4'd0, cnt_pos}) begin
        cb_new = cb_q | (byte_i >> sh);
        cbs_sum = {1'b0, cbs_q} + 5'd8 - {2'd0, sh};
      end else if (sh != 3'd0 && cnt_q == {4'd0, cnt_pos} + 12'd1) begin
        cb_new = cb_q | (byte_i << (4'd8 - {1'b0, sh}));
        cbs_sum = {1'b0, cbs_q} + {2'd0, sh};
      end
      cbs_d = (cbs_sum > 5'd8) ? 4'd8 : cbs_sum[3:0];
      if (cnt_q < e2e_pkg::ByteCntMax) cnt_d = cnt_q + 12'd1;
    end
    cb_d = cb_new;
    if (in_fire_i && last_i) begin
      crc_d = '1; cnt_d = '0; rxc_d = '0; crcs_d = '0; cb_d = '0; cbs_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '1; cnt_q <= '0; rxc_q <= '0; crcs_q <= '0; cb_q <= '0; cbs_q <= '0;
      frame_valid_o <= 1'b0;
    end else begin
      crc_q <= crc_d; cnt_q <= cnt_d; rxc_q <= rxc_d; crcs_q <= crcs_d;
      cb_q <= cb_d; cbs_q <= cbs_d;
      frame_valid_o <= in_fire_i && last_i;
    end
  end

  // Frame summary built from the last byte's updates; the length is pos + 1.
  always_ff @(posedge clk_i) begin
    if (in_fire_i && last_i) begin
      frame_o.length <= {1'b0, cnt_q} + 13'd1;
      frame_o.crc    <= e2e_pkg::crc_byte(crc_q, in_crc ? 8'd0 : byte_i);
      frame_o.rx_crc <= (in_crc && crcs_q < 3'd4) ? {rxc_q[23:0], byte_i} : rxc_q;
      frame_o.crc_ok <= (in_crc && crcs_q < 3'd4) ? (crcs_q == 3'd3) : (crcs_q == 3'd4);
      frame_o.cnt    <= cb_new;
      frame_o.cnt_ok <= (cbs_sum >= 5'd8);
    end
  end
endmodule

// ----- hw/rtl/e2e_fifo.sv -----
// Short two-entry queue of frame summaries between front and back.
// Depends on e2e_pkg.
module e2e_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  e2e_pkg::frame_t data_i,
  output logic            full_o,
  output logic            empty_o,
  input  logic            pop_i,
  output e2e_pkg::frame_t data_o
);
  e2e_pkg::frame_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

// ----- hw/rtl/e2e_back.sv -----
// Back part: data ID fold-in, length/CRC/counter check and output register.
// Depends on e2e_pkg.
module e2e_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  e2e_pkg::frame_t frame_i,
  output logic            req_pop_o,
  input  logic [11:0]     min_len_i,
  input  logic [11:0]     max_len_i,
  input  logic [31:0]     data_id_i,
  input  logic            inc_id_i,
  input  logic [7:0]      max_delta_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [21:0]     out_data_o
);
  logic [31:0] calc;
  logic [7:0]  last_q, delta;
  logic        first_q;
  e2e_pkg::status_e st;
  logic [7:0]  lost;
  logic [1:0]  sm;
  logic        err, upd;

  assign req_pop_o = req_valid_i && (!out_valid_o || out_ready_i);

  always_comb begin
    calc = frame_i.crc;
    if (inc_id_i) begin
      calc = e2e_pkg::crc_byte(calc, data_id_i[7:0]);
      calc = e2e_pkg::crc_byte(calc, data_id_i[15:8]);
      calc = e2e_pkg::crc_byte(calc, data_id_i[23:16]);
      calc = e2e_pkg::crc_byte(calc, data_id_i[31:24]);
    end
    calc = ~calc;
    delta = frame_i.cnt - last_q;
    lost = '0;
    upd = 1'b0;
    if (frame_i.length < {1'b0, min_len_i} || frame_i.length > {1'b0, max_len_i})
      st = e2e_pkg::ST_WRONG_CRC;
    else if (frame_i.length > 13'(e2e_pkg::MaxFrameBytes))
      st = e2e_pkg::ST_INPUT_ERR;
    else if (!frame_i.crc_ok || frame_i.rx_crc != calc || !frame_i.cnt_ok)
      st = e2e_pkg::ST_WRONG_CRC;
    else if (!first_q) begin
      st = e2e_pkg::ST_INITIAL; upd = 1'b1;
    end else if (delta == 8'd0)
      st = e2e_pkg::ST_REPEATED;
    else if (delta == 8'd1) begin
      st = e2e_pkg::ST_OK; upd = 1'b1;
    end else if (delta <= max_delta_i) begin
      st = e2e_pkg::ST_SOME_LOST; lost = delta - 8'd1; upd = 1'b1;
    end else begin
      st = e2e_pkg::ST_SYNC; upd = 1'b1;
    end
    err = 1'b0;
    unique case (st)
      e2e_pkg::ST_OK, e2e_pkg::ST_SOME_LOST: sm = 2'd0;
      e2e_pkg::ST_REPEATED, e2e_pkg::ST_WRONG_CRC: begin
        sm = 2'd1; err = 1'b1;
      end
      e2e_pkg::ST_SYNC: sm = 2'd2;
      e2e_pkg::ST_INITIAL: sm = 2'd3;
      default: sm = 2'd1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0; first_q <= 1'b0; last_q <= '0;
    end else begin
      if (req_pop_o) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      if (req_pop_o && upd) begin
        first_q <= 1'b1; last_q <= frame_i.cnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) out_data_o <= {err, sm, frame_i.cnt, lost, st};
  end
endmodule

// ----- hw/rtl/e2e_crc32_frame_check.sv -----
// Receive-side frame checker: CRC-32 over a byte stream with an 8-bit
// sequence counter check.
// Slave channel: one frame byte per request in s_axis_tdata, tlast on the
// final byte. Master channel: one result per frame, packed in m_axis_tdata
// as status[2:0], lost_count[10:3], received_counter[18:11],
// sm_state[20:19], sm_error[21].
// A result passes the front summary register, the queue and the back
// output register before it is offered on the master channel.
// Throughput: one byte per cycle while s_axis_tready is high; frames of
// a single byte can also be taken every cycle while results are accepted.
// Reset: configuration returns to its defaults, counter history clears,
// the queue and output register empty.
// Stalls: the queue holds two frame results plus the output register;
// s_axis_tready drops when the queue, counting a summary still in the
// front register, would need a third entry that the back cannot free.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must write it only while the block is idle, which the block does not enforce.
`include "assert_macros.svh"
module e2e_crc32_frame_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic        s_axis_tlast,  // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // status, lost_count, received_counter, sm_state, sm_error
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  logic [11:0] min_len_q, max_len_q;
  logic [10:0] crc_ofs_q, cnt_ofs_q;
  logic [31:0] data_id_q;
  logic        inc_id_q;
  logic [7:0]  max_delta_q;
  logic        in_fire, fv, full, empty, pop;
  e2e_pkg::frame_t fr, fq;
  logic [21:0] od;

  // Room for the frame in flight in the front register is kept free.
  assign s_axis_tready = full ? (pop && !fv) : (empty || !fv || pop);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= '0; max_len_q <= 12'd256; crc_ofs_q <= '0; cnt_ofs_q <= 11'd32;
      data_id_q <= '0; inc_id_q <= 1'b0; max_delta_q <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        e2e_pkg::REG_MIN_LEN:   min_len_q <= cfg_data_i[11:0];
        e2e_pkg::REG_MAX_LEN:   max_len_q <= cfg_data_i[11:0];
        e2e_pkg::REG_CRC_OFS:   crc_ofs_q <= cfg_data_i[10:0];
        e2e_pkg::REG_CNT_OFS:   cnt_ofs_q <= cfg_data_i[10:0];
        e2e_pkg::REG_DATA_ID:   data_id_q <= cfg_data_i;
        e2e_pkg::REG_INC_ID:    inc_id_q <= cfg_data_i[0];
        e2e_pkg::REG_MAX_DELTA: max_delta_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  e2e_front u_front (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .byte_i(s_axis_tdata), .last_i(s_axis_tlast),
    .crc_ofs_i(crc_ofs_q), .cnt_ofs_i(cnt_ofs_q), .frame_valid_o(fv), .frame_o(fr)
  );

  e2e_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(fv), .data_i(fr), .full_o(full), .empty_o(empty),
    .pop_i(pop), .data_o(fq)
  );

  e2e_back u_back (
    .clk_i, .rst_ni, .req_valid_i(!empty), .frame_i(fq), .req_pop_o(pop),
    .min_len_i(min_len_q), .max_len_i(max_len_q), .data_id_i(data_id_q),
    .inc_id_i(inc_id_q), .max_delta_i(max_delta_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(od)
  );

  assign m_axis_tdata = {2'b00, od};

  `ASSERT_IMPL(a_no_overflow, fv, !full || pop, "queue overflow")
  `ASSERT_IMPL(a_pop_nonempty, pop, !empty, "pop from empty queue")
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
endmodule
